FILE: hw/rtl/imsu_pkg.sv
// ----------------------------------------------------------------------------
// imsu_pkg
// Shared constants, codes and controller/datapath interface types for the
// Ising Metropolis spin update core.
// ----------------------------------------------------------------------------
`default_nettype none

package imsu_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int PROB_BITS  = 16;

  localparam int OP_W       = 2;
  localparam int SITE_W     = 12;
  localparam int RND_W      = 16;
  localparam int THR_W      = 17;
  localparam int SIDE_W     = 7;
  localparam int MAG_W      = 14;
  localparam int EN_W       = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_TWO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;
  localparam logic [THR_W-1:0]  THR_RESET  = 17'd65536;

  // Random word keeps only PROB_BITS of fraction
  localparam logic [RND_W-1:0] RND_MASK =
      (PROB_BITS >= RND_W) ? {RND_W{1'b1}} : RND_W'((1 << PROB_BITS) - 1);

  typedef enum logic [4:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_NBR,
    ST_RD_SITE,
    ST_RD_UP,
    ST_RD_DN,
    ST_RD_RT,
    ST_RD_LF,
    ST_DECIDE,
    ST_WRITE,
    ST_M_SITE,
    ST_M_RIGHT,
    ST_M_DOWN,
    ST_M_ACC,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    RA_SITE,
    RA_UP,
    RA_DN,
    RA_RT,
    RA_LF,
    RA_MIDX,
    RA_MRIGHT,
    RA_MDOWN
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    nbr_calc;
    rd_sel_e rd_sel;
    logic    cap_site;
    logic    cap_nbr;
    logic    cap_right;
    logic    meas_acc;
    logic    wr_spin;
    logic    clr_step;
    logic    res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad;
    logic div_last;
    logic clr_last;
    logic meas_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/imsu_ram.sv
// ----------------------------------------------------------------------------
// imsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imsu_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/imsu_ctrl.sv
// ----------------------------------------------------------------------------
// imsu_ctrl
// Sequencer: steps the datapath through site update, lattice measurement
// and lattice clear, and hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imsu_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [imsu_pkg::OP_W-1:0] op_i,
  output logic                      in_ready_o,
  input  imsu_pkg::ctrl_sts_t       sts_i,
  output imsu_pkg::ctrl_cmd_t       cmd_o
);

  import imsu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (op_i)
            OP_UPDATE:  state_d = ST_CHECK;
            OP_MEASURE: state_d = ST_M_SITE;
            OP_RESTORE: state_d = ST_CLEAR;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_CHECK: begin
        state_d = sts_i.bad ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_NBR;
        end
      end
      ST_NBR: begin
        cmd_o.nbr_calc = 1'b1;
        state_d        = ST_RD_SITE;
      end
      // Read data is registered and arrives in the state after its address
      ST_RD_SITE: begin
        cmd_o.rd_sel = RA_SITE;
        state_d      = ST_RD_UP;
      end
      ST_RD_UP: begin
        cmd_o.rd_sel   = RA_UP;
        cmd_o.cap_site = 1'b1;
        state_d        = ST_RD_DN;
      end
      ST_RD_DN: begin
        cmd_o.rd_sel  = RA_DN;
        cmd_o.cap_nbr = 1'b1;
        state_d       = ST_RD_RT;
      end
      ST_RD_RT: begin
        cmd_o.rd_sel  = RA_RT;
        cmd_o.cap_nbr = 1'b1;
        state_d       = ST_RD_LF;
      end
      ST_RD_LF: begin
        cmd_o.rd_sel  = RA_LF;
        cmd_o.cap_nbr = 1'b1;
        state_d       = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.cap_nbr = 1'b1;
        state_d       = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr_spin = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_M_SITE: begin
        cmd_o.rd_sel = RA_MIDX;
        state_d      = ST_M_RIGHT;
      end
      ST_M_RIGHT: begin
        cmd_o.rd_sel   = RA_MRIGHT;
        cmd_o.cap_site = 1'b1;
        state_d        = ST_M_DOWN;
      end
      ST_M_DOWN: begin
        cmd_o.rd_sel    = RA_MDOWN;
        cmd_o.cap_right = 1'b1;
        state_d         = ST_M_ACC;
      end
      ST_M_ACC: begin
        cmd_o.meas_acc = 1'b1;
        state_d        = sts_i.meas_last ? ST_FINISH : ST_M_SITE;
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/imsu_dpath.sv
// ----------------------------------------------------------------------------
// imsu_dpath
// Datapath: configuration registers, spin memory, column divider,
// neighbor address unit, flip decision, lattice sums and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imsu_dpath #(
  parameter int MaxSide = imsu_pkg::MAX_SIDE
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [imsu_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic [imsu_pkg::OP_W-1:0]              op_i,
  input  logic [imsu_pkg::SITE_W-1:0]            site_index_i,
  input  logic [imsu_pkg::RND_W-1:0]             random_fraction_i,
  input  imsu_pkg::ctrl_cmd_t                    cmd_i,
  output imsu_pkg::ctrl_sts_t                    sts_o,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   flipped_o,
  output logic                                   new_spin_o,
  output logic signed [imsu_pkg::MAG_W-1:0]      magnetization_sum_o,
  output logic signed [imsu_pkg::EN_W-1:0]       energy_sum_o,
  output logic                                   bad_index_o
);

  import imsu_pkg::*;

  localparam int QW     = $clog2(MaxSide);
  localparam int QW1    = QW + 1;
  localparam int SW     = $clog2(MaxSide + 1);
  localparam int IW     = 2 * QW;
  localparam int CW     = IW + 1;
  localparam int XW     = (CW > SITE_W) ? CW : SITE_W;
  localparam int DEPTH  = MaxSide * MaxSide;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DCW    = $clog2(QW + 1);

  // Configuration
  logic [SIDE_W-1:0] side_cfg_q;
  logic [THR_W-1:0]  thr_two_q;
  logic [THR_W-1:0]  thr_four_q;

  // Control state
  logic              out_valid_q;
  logic [DCW-1:0]    div_cnt_q;
  logic [ADDR_W-1:0] clr_q;
  logic [IW-1:0]     midx_q;
  logic [QW-1:0]     mrow_q;
  logic [QW-1:0]     mcol_q;

  // Payload
  logic [OP_W-1:0]   op_q;
  logic [SITE_W-1:0] site_q;
  logic [RND_W-1:0]  rnd_q;
  logic [CW-1:0]     vol_q;
  logic [QW:0]       rem_q;
  logic [QW-1:0]     lo_q;
  logic [ADDR_W-1:0] up_q, dn_q, rt_q, lf_q;
  logic [2:0]        ups_q;
  logic              s_q;
  logic              right_q;
  logic [MAG_W-1:0]  mag_q;
  logic [EN_W-1:0]   en_q;
  logic              res_flip_q, res_new_q, res_bad_q;
  logic [MAG_W-1:0]  res_mag_q;
  logic [EN_W-1:0]   res_en_q;

  // Combinational
  logic [SW-1:0]     side;
  logic [CW-1:0]     sd;
  logic              bad;
  logic [XW-1:0]     site_in_x;
  logic [XW-1:0]     site_x;
  logic [ADDR_W-1:0] sidx;
  logic [QW:0]       div_t;
  logic [QW:0]       rem_d;
  logic [CW-1:0]     s_c, c_c, up_t, up_c, dn_c, rt_c, lf_c;
  logic [CW-1:0]     mi_c, mr_c, mc_c, right_c, down_c;
  logic              col_end, row_end;
  logic [2:0]        k;
  logic              lt_two, lt_four, flip;
  logic              ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic              flip_r, new_r, bad_r;
  logic [MAG_W-1:0]  mag_r;
  logic [EN_W-1:0]   en_r;
  logic [EN_W-1:0]   en_pr, en_pd;

  // Side in use: zero reads as one, oversize clamps to the lattice maximum
  always_comb begin
    if (side_cfg_q == '0) begin
      side = SW'(1);
    end else if (32'(side_cfg_q) > 32'(MaxSide)) begin
      side = SW'(MaxSide);
    end else begin
      side = SW'(side_cfg_q);
    end
  end

  assign sd        = CW'(side);
  assign site_x    = XW'(site_q);
  assign site_in_x = XW'(site_index_i);
  assign bad       = site_x >= XW'(vol_q);
  assign sidx      = site_x[ADDR_W-1:0];

  // Restoring division, one quotient bit a cycle; only the remainder is kept
  assign div_t = {rem_q[QW-1:0], lo_q[QW-1]};
  assign rem_d = (div_t >= QW1'(side)) ? div_t - QW1'(side) : div_t;

  // Periodic neighbors of the update site
  always_comb begin
    s_c  = CW'(site_q);
    c_c  = CW'(rem_q[QW-1:0]);
    up_t = s_c + sd;
    up_c = (up_t >= vol_q) ? up_t - vol_q : up_t;
    dn_c = (s_c < sd) ? s_c + vol_q - sd : s_c - sd;
    rt_c = (c_c == sd - CW'(1)) ? s_c - c_c : s_c + CW'(1);
    lf_c = (c_c == '0) ? s_c + sd - CW'(1) : s_c - CW'(1);
  end

  // Forward neighbors of the measurement walk
  always_comb begin
    mi_c    = CW'(midx_q);
    mr_c    = CW'(mrow_q);
    mc_c    = CW'(mcol_q);
    col_end = mc_c == sd - CW'(1);
    row_end = mr_c == sd - CW'(1);
    right_c = col_end ? mi_c - mc_c : mi_c + CW'(1);
    down_c  = row_end ? mc_c : mi_c + sd;
  end

  // Count of aligned neighbors seen from the site: up count, or down count
  always_comb begin
    k       = s_q ? ups_q : 3'd4 - ups_q;
    lt_two  = THR_W'(rnd_q) < thr_two_q;
    lt_four = THR_W'(rnd_q) < thr_four_q;
    if (k <= 3'd2) begin
      flip = 1'b1;
    end else if (k == 3'd3) begin
      flip = lt_two;
    end else begin
      flip = lt_four;
    end
  end

  assign en_pr = (s_q ^ right_q)   ? EN_W'(1) : {EN_W{1'b1}};
  assign en_pd = (s_q ^ ram_rdata) ? EN_W'(1) : {EN_W{1'b1}};

  always_comb begin
    unique case (cmd_i.rd_sel)
      RA_SITE:   ram_raddr = sidx;
      RA_UP:     ram_raddr = up_q;
      RA_DN:     ram_raddr = dn_q;
      RA_RT:     ram_raddr = rt_q;
      RA_LF:     ram_raddr = lf_q;
      RA_MIDX:   ram_raddr = midx_q[ADDR_W-1:0];
      RA_MRIGHT: ram_raddr = right_c[ADDR_W-1:0];
      RA_MDOWN:  ram_raddr = down_c[ADDR_W-1:0];
      default:   ram_raddr = sidx;
    endcase
  end

  assign ram_we    = cmd_i.clr_step | (cmd_i.wr_spin & flip);
  assign ram_waddr = cmd_i.clr_step ? clr_q : sidx;
  assign ram_wdata = cmd_i.clr_step ? 1'b1 : ~s_q;

  imsu_ram #(
    .Width (1),
    .Depth (DEPTH)
  ) u_spin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result word: fields the op does not produce stay zero
  always_comb begin
    flip_r = 1'b0;
    new_r  = 1'b0;
    bad_r  = 1'b0;
    mag_r  = '0;
    en_r   = '0;
    case (op_q)
      OP_UPDATE: begin
        if (bad) begin
          bad_r = 1'b1;
        end else begin
          flip_r = flip;
          new_r  = s_q ^ flip;
        end
      end
      OP_MEASURE: begin
        mag_r = mag_q;
        en_r  = en_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cfg_q  <= SIDE_RESET;
      thr_two_q   <= THR_RESET;
      thr_four_q  <= THR_RESET;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      clr_q       <= '0;
      midx_q      <= '0;
      mrow_q      <= '0;
      mcol_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SIDE:     side_cfg_q <= cfg_wdata_i[SIDE_W-1:0];
          CFG_THR_TWO:  thr_two_q  <= cfg_wdata_i[THR_W-1:0];
          CFG_THR_FOUR: thr_four_q <= cfg_wdata_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        div_cnt_q <= '0;
        clr_q     <= '0;
        midx_q    <= '0;
        mrow_q    <= '0;
        mcol_q    <= '0;
      end else begin
        if (cmd_i.div_step) begin
          div_cnt_q <= div_cnt_q + DCW'(1);
        end
        if (cmd_i.clr_step) begin
          clr_q <= clr_q + ADDR_W'(1);
        end
        if (cmd_i.meas_acc) begin
          midx_q <= midx_q + IW'(1);
          if (col_end) begin
            mcol_q <= '0;
            mrow_q <= mrow_q + QW'(1);
          end else begin
            mcol_q <= mcol_q + QW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vol_q <= sd * sd;
    if (cmd_i.load) begin
      op_q   <= op_i;
      site_q <= site_index_i;
      rnd_q  <= random_fraction_i & RND_MASK;
      // Start the division from the high half of the index
      rem_q  <= QW1'(site_in_x[IW-1:QW]);
      lo_q   <= site_in_x[QW-1:0];
      mag_q  <= '0;
      en_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      lo_q  <= lo_q << 1;
    end
    if (cmd_i.nbr_calc) begin
      up_q  <= up_c[ADDR_W-1:0];
      dn_q  <= dn_c[ADDR_W-1:0];
      rt_q  <= rt_c[ADDR_W-1:0];
      lf_q  <= lf_c[ADDR_W-1:0];
      ups_q <= '0;
    end
    if (cmd_i.cap_site) begin
      s_q <= ram_rdata;
    end
    if (cmd_i.cap_nbr) begin
      ups_q <= ups_q + {2'b00, ram_rdata};
    end
    if (cmd_i.cap_right) begin
      right_q <= ram_rdata;
    end
    if (cmd_i.meas_acc) begin
      mag_q <= mag_q + (s_q ? MAG_W'(1) : {MAG_W{1'b1}});
      en_q  <= en_q + en_pr + en_pd;
    end
    if (cmd_i.res_load) begin
      res_flip_q <= flip_r;
      res_new_q  <= new_r;
      res_bad_q  <= bad_r;
      res_mag_q  <= mag_r;
      res_en_q   <= en_r;
    end
  end

  assign sts_o.bad       = bad;
  assign sts_o.div_last  = div_cnt_q == DCW'(QW - 1);
  assign sts_o.clr_last  = clr_q == ADDR_W'(DEPTH - 1);
  assign sts_o.meas_last = row_end & col_end;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign flipped_o           = res_flip_q;
  assign new_spin_o          = res_new_q;
  assign bad_index_o         = res_bad_q;
  assign magnetization_sum_o = $signed(res_mag_q);
  assign energy_sum_o        = $signed(res_en_q);

`ifndef SYNTHESIS
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> sts_o.out_free)
    else $error("result loaded over an untaken word");

  a_no_write_bad_site: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_spin |-> !bad)
    else $error("spin write for an out-of-range site");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !bad) |=> (rem_q < QW1'(side)))
    else $error("column remainder not below side");

  a_nbr_in_lattice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.nbr_calc |=> ((CW'(up_q) < vol_q) && (CW'(dn_q) < vol_q) &&
                        (CW'(rt_q) < vol_q) && (CW'(lf_q) < vol_q)))
    else $error("neighbor address outside the lattice");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ising_metropolis_spin_update_core.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_core: 2D Ising Metropolis update engine
// Update: the column remainder is built one bit per cycle, then the site and
//   its four neighbors are read from spin memory, one read per cycle, before
//   the flip decision and the spin write.
// A bad index or an unused op goes straight to the result; measure walks all
//   side^2 sites and restore clears all MaxSide^2 sites;
//   a stalled output word holds off the next accept.
// Reset: clear pass over all MaxSide^2 sites with in_ready_o low.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_spin_update_core #(
  parameter int MaxSide = imsu_pkg::MAX_SIDE
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [imsu_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [imsu_pkg::OP_W-1:0]              op_i,
  input  logic [imsu_pkg::SITE_W-1:0]            site_index_i,
  input  logic [imsu_pkg::RND_W-1:0]             random_fraction_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   flipped_o,
  output logic                                   new_spin_o,
  output logic signed [imsu_pkg::MAG_W-1:0]      magnetization_sum_o,
  output logic signed [imsu_pkg::EN_W-1:0]       energy_sum_o,
  output logic                                   bad_index_o
);

  import imsu_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  imsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  imsu_dpath #(
    .MaxSide (MaxSide)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .op_i                (op_i),
    .site_index_i        (site_index_i),
    .random_fraction_i   (random_fraction_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .flipped_o           (flipped_o),
    .new_spin_o          (new_spin_o),
    .magnetization_sum_o (magnetization_sum_o),
    .energy_sum_o        (energy_sum_o),
    .bad_index_o         (bad_index_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_ising_metropolis_spin_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ising_metropolis_spin_update_core
// Drives site updates, lattice measurements, restores and the unused op into
// the spin update core. A local copy of the spin lattice and of the register
// settings predicts each result word, which is checked in order on the output
// side. Directed words cover the corner cases. Random words then run under a
// series of lattice sizes and flip thresholds, with random idle cycles on
// both channels.
// ----------------------------------------------------------------------------
module tb_ising_metropolis_spin_update_core;
  import imsu_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LATTICE_BITS = MAX_SIDE * MAX_SIDE;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int JUNK_W = CFG_DATA_W - SIDE_W;

  typedef struct packed {
    logic                    flipped;
    logic                    new_spin;
    logic signed [MAG_W-1:0] magnet;
    logic signed [EN_W-1:0]  energy;
    logic                    bad;
  } outcome_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SITE_W-1:0] site;
    logic [RND_W-1:0]  rnd;
    int unsigned       gap;
  } site_op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_SIDE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OP_W-1:0] op_i = OP_UPDATE;
  logic [SITE_W-1:0] site_index_i = '0;
  logic [RND_W-1:0] random_fraction_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic flipped_o;
  logic new_spin_o;
  logic signed [MAG_W-1:0] magnetization_sum_o;
  logic signed [EN_W-1:0] energy_sum_o;
  logic bad_index_o;

  // Local lattice copy and register settings
  bit spin_mirror [LATTICE_BITS] = '{default: 1'b1};
  logic [SIDE_W-1:0] side_cfg = SIDE_RESET;
  logic [THR_W-1:0] thr_two_cfg = THR_RESET;
  logic [THR_W-1:0] thr_four_cfg = THR_RESET;

  site_op_t site_ops_q[$];
  outcome_t outcome_q[$];
  bit idle_on = 1'b1;

  site_op_t next_op;
  outcome_t predicted, got, want;
  int unsigned gap_cnt, ready_wait, draw, stall_cycles;
  int unsigned n_updates, n_flips, n_bad, n_measures, n_restores, n_unused;
  int unsigned n_results, n_err, n_settings;

  ising_metropolis_spin_update_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .site_index_i       (site_index_i),
    .random_fraction_i  (random_fraction_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .flipped_o          (flipped_o),
    .new_spin_o         (new_spin_o),
    .magnetization_sum_o(magnetization_sum_o),
    .energy_sum_o       (energy_sum_o),
    .bad_index_o        (bad_index_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned lattice_side();
    int unsigned s;
    s = 32'(side_cfg);
    if (s == 0) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  function automatic int spin_of(input int unsigned row, col, side);
    return spin_mirror[row * side + col] ? 1 : -1;
  endfunction

  // Apply one word to the lattice copy and return the result it should give
  function automatic outcome_t metropolis_step(input logic [OP_W-1:0] op,
                                               input logic [SITE_W-1:0] site,
                                               input logic [RND_W-1:0] rnd);
    outcome_t o;
    int unsigned side, vol, row, col, r;
    int s, nsum, prod, mag, en;
    logic flip;
    o = '0;
    side = lattice_side();
    vol = side * side;
    r = 32'(rnd & RND_MASK);
    case (op)
      OP_UPDATE: begin
        if (site >= vol) begin
          o.bad = 1'b1;
        end else begin
          row = site / side;
          col = site % side;
          s = spin_of(row, col, side);
          nsum = spin_of((row + 1) % side, col, side)
               + spin_of((row + side - 1) % side, col, side)
               + spin_of(row, (col + 1) % side, side)
               + spin_of(row, (col + side - 1) % side, side);
          prod = s * nsum;
          if (prod <= 0) flip = 1'b1;
          else if (prod == 2) flip = (r < thr_two_cfg);
          else flip = (r < thr_four_cfg);
          if (flip) spin_mirror[site] = ~spin_mirror[site];
          o.flipped = flip;
          o.new_spin = spin_mirror[site];
        end
      end
      OP_MEASURE: begin
        mag = 0;
        en = 0;
        for (int unsigned rw = 0; rw < side; rw++) begin
          for (int unsigned cl = 0; cl < side; cl++) begin
            s = spin_of(rw, cl, side);
            mag += s;
            en -= s * spin_of(rw, (cl + 1) % side, side);
            en -= s * spin_of((rw + 1) % side, cl, side);
          end
        end
        o.magnet = mag[MAG_W-1:0];
        o.energy = en[EN_W-1:0];
      end
      OP_RESTORE: spin_mirror = '{default: 1'b1};
      default: ;
    endcase
    return o;
  endfunction

  // Driver: present queued words, predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= OP_UPDATE;
      site_index_i <= '0;
      random_fraction_i <= '0;
      gap_cnt <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted = metropolis_step(op_i, site_index_i, random_fraction_i);
        outcome_q.push_back(predicted);
        case (op_i)
          OP_UPDATE: begin
            n_updates++;
            n_flips += 32'(predicted.flipped);
            n_bad += 32'(predicted.bad);
          end
          OP_MEASURE: n_measures++;
          OP_RESTORE: n_restores++;
          default: n_unused++;
        endcase
      end
      if (!in_valid_i || in_ready_o) begin
        if (site_ops_q.size() != 0 && gap_cnt >= site_ops_q[0].gap) begin
          next_op = site_ops_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= next_op.op;
          site_index_i <= next_op.site;
          random_fraction_i <= next_op.rnd;
          gap_cnt <= 0;
        end else begin
          in_valid_i <= 1'b0;
          if (site_ops_q.size() != 0) gap_cnt <= gap_cnt + 1;
        end
      end
    end
  end

  // Monitor: stall at random, check each result word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_wait <= 1;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        got = {flipped_o, new_spin_o, magnetization_sum_o, energy_sum_o, bad_index_o};
        if (outcome_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result word: flipped %0b new_spin %0b mag %0d energy %0d bad %0b",
                   $time, got.flipped, got.new_spin, got.magnet, got.energy, got.bad);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            n_err++;
            $display("%0t: result %0d expected flipped %0b new_spin %0b mag %0d energy %0d bad %0b",
                     $time, n_results, want.flipped, want.new_spin, want.magnet, want.energy,
                     want.bad);
            $display("%0t: result %0d actual   flipped %0b new_spin %0b mag %0d energy %0d bad %0b",
                     $time, n_results, got.flipped, got.new_spin, got.magnet, got.energy,
                     got.bad);
          end
        end
        draw = idle_on ? $urandom_range(0, 17) : 0;
        out_ready_i <= (draw == 0);
        ready_wait <= draw;
      end else if (ready_wait != 0) begin
        out_ready_i <= (ready_wait == 1);
        ready_wait <= ready_wait - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, outcome_q.size());
      $display("ising_metropolis_spin_update_core: mismatch");
      $finish;
    end
  end

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [SITE_W-1:0] site,
                          input logic [RND_W-1:0] rnd);
    site_op_t w;
    w.op = op;
    w.site = site;
    w.rnd = rnd;
    w.gap = idle_on ? $urandom_range(0, 17) : 0;
    site_ops_q.push_back(w);
  endtask

  // Wait until every queued word is taken and every result is back
  task automatic settle();
    while (site_ops_q.size() != 0 || in_valid_i || outcome_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_lattice(input logic [SIDE_W-1:0] side,
                                 input logic [THR_W-1:0] t2, input logic [THR_W-1:0] t4);
    logic [JUNK_W-1:0] junk;
    settle();
    junk = JUNK_W'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_SIDE;
    cfg_wdata_i <= {junk, side};  // upper bits are not part of the side register
    @(posedge clk_i);
    cfg_index_i <= CFG_THR_TWO;
    cfg_wdata_i <= t2;
    @(posedge clk_i);
    cfg_index_i <= CFG_THR_FOUR;
    cfg_wdata_i <= t4;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    side_cfg = side;
    thr_two_cfg = t2;
    thr_four_cfg = t4;
    n_settings++;
    @(negedge clk_i);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned side, vol, pick, thr;
    logic [OP_W-1:0] op;
    logic [SITE_W-1:0] site;
    logic [RND_W-1:0] rnd;
    side = lattice_side();
    vol = side * side;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      site = SITE_W'($urandom_range(0, vol - 1));
      rnd = RND_W'($urandom);
      if (pick < 12) begin
        // land right at or just below a threshold
        thr = $urandom_range(0, 1) ? thr_two_cfg : thr_four_cfg;
        if (thr != 0) thr = thr - $urandom_range(0, 1);
        rnd = (thr > 32'hFFFF) ? '1 : RND_W'(thr);
      end
      op = OP_UPDATE;
      if (pick >= 76 && pick < 86 && vol < LATTICE_BITS) begin
        site = SITE_W'($urandom_range(vol, LATTICE_BITS - 1));
      end else if (pick >= 86 && pick < 92 && (side <= 16 || $urandom_range(0, 39) == 0)) begin
        op = OP_MEASURE;
      end else if (pick >= 92 && pick < 96) begin
        op = OP_RESTORE;
      end else if (pick >= 96) begin
        op = OP_UNUSED;
        site = SITE_W'($urandom);
      end
      queue_op(op, site, rnd);
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Full lattice at reset settings: every threshold flips
    queue_op(OP_MEASURE, '0, '0);
    queue_op(OP_UPDATE, 12'd0, 16'hFFFF);
    queue_op(OP_UPDATE, 12'd1, 16'h0000);
    queue_op(OP_UPDATE, 12'd0, 16'h8000);
    queue_op(OP_UPDATE, 12'hFFF, 16'hFFFF);
    queue_op(OP_UNUSED, 12'hFFF, 16'hFFFF);

    // Side of one: the site is its own neighbor; zero thresholds never flip
    program_lattice(7'd1, '0, '0);
    queue_op(OP_UPDATE, 12'd0, 16'h0000);
    queue_op(OP_UPDATE, 12'd1, 16'h0000);
    queue_op(OP_UPDATE, 12'hFFF, 16'hFFFF);
    queue_op(OP_MEASURE, '0, '0);

    // Side of four reads the old bits with the new geometry
    program_lattice(7'd4, '0, THR_RESET);
    queue_op(OP_UPDATE, 12'd0, 16'hFFFF);
    queue_op(OP_UPDATE, 12'd2, 16'hFFFF);
    queue_op(OP_UPDATE, 12'd1, 16'hFFFF);
    queue_op(OP_UPDATE, 12'd3, 16'h0000);
    queue_op(OP_UPDATE, 12'd5, 16'h0000);
    queue_op(OP_MEASURE, '0, '0);
    queue_op(OP_RESTORE, 12'h5A5, 16'hA5A5);

    // Restore must have cleared beyond the small lattice
    program_lattice(SIDE_RESET, THR_RESET, THR_RESET);
    queue_op(OP_MEASURE, 12'hFFF, 16'hFFFF);
    queue_op(OP_UPDATE, 12'd4032, 16'h7FFF);

    program_lattice(7'd4, 17'd32768, 17'd8192);
    queue_random(70);
    idle_on = 1'b0;
    program_lattice(7'd8, THR_W'($urandom_range(0, 65536)), THR_W'($urandom_range(0, 65536)));
    queue_random(70);
    idle_on = 1'b1;
    program_lattice(7'd2, THR_RESET, '0);
    queue_random(40);
    program_lattice(7'd0, '0, THR_RESET);
    queue_random(25);
    program_lattice(7'd5, THR_W'($urandom_range(0, 65536)), THR_W'($urandom_range(0, 65536)));
    queue_random(60);
    program_lattice(7'd127, 17'd20000, 17'd3000);
    queue_random(70);
    program_lattice(7'd3, 17'd65535, 17'd1);
    queue_random(50);
    program_lattice(7'd16, THR_W'($urandom_range(0, 65536)), THR_W'($urandom_range(0, 65536)));
    queue_random(70);
    idle_on = 1'b0;
    program_lattice(7'd7, '0, '0);
    queue_random(30);
    idle_on = 1'b1;
    program_lattice(SIDE_RESET, THR_W'($urandom_range(0, 65536)),
                    THR_W'($urandom_range(0, 65536)));
    queue_random(50);

    settle();
    repeat (64) @(negedge clk_i);
    $display("covered %0d site updates (%0d flips, %0d out of range), %0d measurements,",
             n_updates, n_flips, n_bad, n_measures);
    $display("%0d restores and %0d unused ops over %0d lattice settings; %0d words checked",
             n_restores, n_unused, n_settings, n_results);
    if (n_err == 0 && outcome_q.size() == 0) begin
      $display("ising_metropolis_spin_update_core: match");
    end else begin
      $display("ising_metropolis_spin_update_core: mismatch");
    end
    $finish;
  end

endmodule
